// ===== rtl/core/artanh_taylor_series_core_assert.svh =====
`ifndef ARTANH_TAYLOR_SERIES_CORE_ASSERT_SVH
`define ARTANH_TAYLOR_SERIES_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ATSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ATSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/atsc_pkg.sv =====
package atsc_pkg;

  localparam int FRAC_BITS     = 30;
  localparam int ARG_W         = 31;
  localparam int MAG_W         = FRAC_BITS + 1;
  localparam int SUM_OUT_W     = 35;
  localparam int TERMS_OUT_W   = 9;
  localparam int CFG_W         = 4;
  localparam int DEF_MAX_TERMS = 256;
  localparam int UPC_W         = 3;

  localparam logic [CFG_W-1:0]       PREC_RESET = 4'd6;
  localparam logic [SUM_OUT_W-1:0]   SUM_SAT    = 35'h3_FFFF_FFFF;
  localparam logic [TERMS_OUT_W-1:0] TERMS_SAT  = 9'd511;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SQR,
    OP_MUL,
    OP_MULN,
    OP_DIV,
    OP_NOP,
    OP_ACCUM,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_NO_IN,
    CND_P_LT_EPS,
    CND_NOT_CAP,
    CND_DIV_MORE,
    CND_OUT_BUSY
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UA_IDLE = 3'd0;
  localparam upc_t UA_SQR  = 3'd1;
  localparam upc_t UA_MUL  = 3'd2;
  localparam upc_t UA_MULN = 3'd3;
  localparam upc_t UA_DIV  = 3'd4;
  localparam upc_t UA_TEST = 3'd5;
  localparam upc_t UA_CAP  = 3'd6;
  localparam upc_t UA_DONE = 3'd7;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_word_t;

  typedef struct packed {
    logic p_lt_eps;
    logic cap;
    logic div_more;
  } dp_status_t;

  // jump to target when cond holds, else fall through (DONE wraps to IDLE)
  function automatic ctrl_word_t ucode(input upc_t addr);
    ctrl_word_t cw;
    unique case (addr)
      UA_IDLE: cw = '{op: OP_LOAD,  cond: CND_NO_IN,    target: UA_IDLE};
      UA_SQR:  cw = '{op: OP_SQR,   cond: CND_ALWAYS,   target: UA_TEST};
      UA_MUL:  cw = '{op: OP_MUL,   cond: CND_ALWAYS,   target: UA_MULN};
      UA_MULN: cw = '{op: OP_MULN,  cond: CND_ALWAYS,   target: UA_DIV};
      UA_DIV:  cw = '{op: OP_DIV,   cond: CND_DIV_MORE, target: UA_DIV};
      UA_TEST: cw = '{op: OP_NOP,   cond: CND_P_LT_EPS, target: UA_DONE};
      UA_CAP:  cw = '{op: OP_ACCUM, cond: CND_NOT_CAP,  target: UA_MUL};
      UA_DONE: cw = '{op: OP_OUT,   cond: CND_OUT_BUSY, target: UA_DONE};
      default: cw = '{op: OP_NOP,   cond: CND_ALWAYS,   target: UA_IDLE};
    endcase
    return cw;
  endfunction

  // floor(2^30 / 10^k), least value 1
  function automatic logic [MAG_W-1:0] eps_lookup(input logic [CFG_W-1:0] k);
    logic [MAG_W-1:0] e;
    case (k)
      4'd0:    e = 31'd1073741824;
      4'd1:    e = 31'd107374182;
      4'd2:    e = 31'd10737418;
      4'd3:    e = 31'd1073741;
      4'd4:    e = 31'd107374;
      4'd5:    e = 31'd10737;
      4'd6:    e = 31'd1073;
      4'd7:    e = 31'd107;
      4'd8:    e = 31'd10;
      default: e = 31'd1;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/core/atsc_seq.sv =====
module atsc_seq
  import atsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_free,
  input  dp_status_t status,
  output ctrl_word_t ctrl
);

  upc_t upc_r;
  upc_t upc_nxt;
  logic taken;

  assign ctrl = ucode(upc_r);

  always_comb begin
    unique case (ctrl.cond)
      CND_ALWAYS:   taken = 1'b1;
      CND_NO_IN:    taken = !in_valid;
      CND_P_LT_EPS: taken = status.p_lt_eps;
      CND_NOT_CAP:  taken = !status.cap;
      CND_DIV_MORE: taken = status.div_more;
      CND_OUT_BUSY: taken = !out_free;
      default:      taken = 1'b0;
    endcase
    upc_nxt = taken ? ctrl.target : upc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== rtl/core/atsc_dp.sv =====
module atsc_dp
  import atsc_pkg::*;
#(
  parameter int MAX_TERMS = DEF_MAX_TERMS
) (
  input  logic                        clk,
  input  op_t                         op,
  input  logic signed [ARG_W-1:0]     argument,
  input  logic [CFG_W-1:0]            prec,
  output dp_status_t                  status,
  output logic signed [SUM_OUT_W-1:0] series_sum,
  output logic [TERMS_OUT_W-1:0]      terms_added,
  output logic                        limit_reached
);

  localparam int TW    = $clog2(MAX_TERMS + 1);
  localparam int NW    = $clog2(2 * MAX_TERMS + 4);
  localparam int SW    = (MAG_W + TW > SUM_OUT_W + 1) ? MAG_W + TW : SUM_OUT_W + 1;
  localparam int TXW   = (TW > TERMS_OUT_W) ? TW : TERMS_OUT_W;
  localparam int DVW   = MAG_W + NW;
  localparam int CNT_W = $clog2(MAG_W);
  localparam int PM_W  = 2 * MAG_W;

  logic                neg_r;
  logic [MAG_W-1:0]    mag_r, eps_r, x2_r, p_r, prod_r, quo_r;
  logic [SW-1:0]       sum_r;
  logic [NW-1:0]       n_r, rem_r;
  logic [TW-1:0]       terms_r;
  logic                limit_r;
  logic [CNT_W-1:0]    cnt_r;

  logic [ARG_W:0]      neg_arg;
  logic [MAG_W-1:0]    mag_in, ma, mb;
  logic [PM_W-1:0]     pm;
  logic [DVW-1:0]      dividend;
  logic [NW-1:0]       divisor;
  logic [NW:0]         trial;
  logic                ge;
  logic [SUM_OUT_W-1:0] sat;
  logic [TXW-1:0]      terms_ext;

  assign neg_arg  = {1'b1, {ARG_W{1'b0}}} - {1'b0, argument};
  assign mag_in   = argument[ARG_W-1] ? neg_arg[MAG_W-1:0] : argument;

  assign ma       = (op == OP_SQR) ? mag_r : p_r;
  assign mb       = (op == OP_SQR) ? mag_r : x2_r;
  assign pm       = {{MAG_W{1'b0}}, ma} * {{MAG_W{1'b0}}, mb};

  assign dividend = {{NW{1'b0}}, prod_r} * {{MAG_W{1'b0}}, n_r};
  assign divisor  = n_r + NW'(2);
  assign trial    = {rem_r, quo_r[MAG_W-1]};
  assign ge       = trial >= {1'b0, divisor};

  assign status.p_lt_eps = p_r < eps_r;
  assign status.cap      = terms_r == TW'(MAX_TERMS);
  assign status.div_more = cnt_r != '0;

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        neg_r <= argument[ARG_W-1];
        mag_r <= mag_in;
        eps_r <= eps_lookup(prec);
      end
      OP_SQR: begin
        x2_r    <= pm[FRAC_BITS +: MAG_W];
        p_r     <= mag_r;
        sum_r   <= '0;
        n_r     <= NW'(1);
        terms_r <= '0;
        limit_r <= 1'b0;
      end
      OP_ACCUM: begin
        if (status.cap) begin
          limit_r <= 1'b1;
        end else begin
          sum_r   <= sum_r + SW'(p_r);
          terms_r <= terms_r + 1'b1;
        end
      end
      OP_MUL: begin
        prod_r <= pm[FRAC_BITS +: MAG_W];
      end
      OP_MULN: begin
        rem_r <= dividend[DVW-1 -: NW];
        quo_r <= dividend[MAG_W-1:0];
        cnt_r <= CNT_W'(MAG_W - 1);
      end
      OP_DIV: begin
        rem_r <= ge ? NW'(trial - {1'b0, divisor}) : trial[NW-1:0];
        quo_r <= {quo_r[MAG_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          p_r <= {quo_r[MAG_W-2:0], ge};
          n_r <= n_r + NW'(2);
        end
      end
      OP_NOP, OP_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign sat           = (sum_r > SW'(SUM_SAT)) ? SUM_SAT : sum_r[SUM_OUT_W-1:0];
  assign series_sum    = neg_r ? SUM_OUT_W'(0) - sat : sat;
  assign terms_ext     = TXW'(terms_r);
  assign terms_added   = (terms_ext > TXW'(TERMS_SAT)) ? TERMS_SAT
                                                       : terms_ext[TERMS_OUT_W-1:0];
  assign limit_reached = limit_r;

endmodule

// ===== rtl/core/artanh_taylor_series_core.sv =====
// artanh(x) by its Taylor series x + x^3/3 + x^5/5 + ..., x in signed Q1.30.
// Sums terms until the next term drops below 10^-k (k from cfg_wr_data) or
// MAX_TERMS terms are in; returns the sum in signed Q5.30 (saturated), the
// term count and a cap flag. A small microprogram drives one shared 31x31
// multiplier and a radix-2 divider. Each term takes 4 control steps plus a
// 31-bit division, one quotient bit per cycle. One request is worked at a
// time; the next request is taken while the previous result waits in the
// output register.
module artanh_taylor_series_core
  import atsc_pkg::*;
#(
  parameter int MAX_TERMS = DEF_MAX_TERMS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [ARG_W-1:0]     in_argument,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SUM_OUT_W-1:0] out_series_sum,
  output logic [TERMS_OUT_W-1:0]      out_terms_added,
  output logic                        out_limit_reached,
  input  logic                        cfg_wr_en,
  input  logic [CFG_W-1:0]            cfg_wr_data
);

  `include "artanh_taylor_series_core_assert.svh"

  localparam logic [TERMS_OUT_W-1:0] TERMS_AT_CAP =
    (MAX_TERMS > 511) ? TERMS_SAT : TERMS_OUT_W'(MAX_TERMS);

  logic [CFG_W-1:0]            prec_r;
  logic                        out_valid_r;
  logic signed [SUM_OUT_W-1:0] sum_r;
  logic [TERMS_OUT_W-1:0]      terms_r;
  logic                        limit_r;

  ctrl_word_t                  ctrl;
  dp_status_t                  status;
  logic                        out_free;
  logic                        out_load;
  logic signed [SUM_OUT_W-1:0] dp_sum;
  logic [TERMS_OUT_W-1:0]      dp_terms;
  logic                        dp_limit;

  assign in_ready = (ctrl.op == OP_LOAD);
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (ctrl.op == OP_OUT) && out_free;

  atsc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .status   (status),
    .ctrl     (ctrl)
  );

  atsc_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk           (clk),
    .op            (ctrl.op),
    .argument      (in_argument),
    .prec          (prec_r),
    .status        (status),
    .series_sum    (dp_sum),
    .terms_added   (dp_terms),
    .limit_reached (dp_limit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r      <= PREC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        prec_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (out_load) begin
      sum_r   <= dp_sum;
      terms_r <= dp_terms;
      limit_r <= dp_limit;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_series_sum    = sum_r;
  assign out_terms_added   = terms_r;
  assign out_limit_reached = limit_r;

  `ATSC_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready right after request")
  `ATSC_ASSERT_NOW(a_cap_count, out_valid && out_limit_reached, out_terms_added == TERMS_AT_CAP, "cap flag with short count")
  `ATSC_ASSERT_NOW(a_zero_terms, out_valid && out_terms_added == '0, out_series_sum == '0, "nonzero sum with no terms")

endmodule
